FILE: sv/retry_send_queue_macros.svh
// assertion macros used by the retry send queue scheduler
`ifndef RETRY_SEND_QUEUE_MACROS_SVH
`define RETRY_SEND_QUEUE_MACROS_SVH

// same-cycle implication, disabled during reset
`define RSQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RSQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rsq_pkg.sv
// types and constants of the retry send queue
`default_nettype none

package rsq_pkg;

    localparam int QUEUE_DEPTH = 6;
    localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int CMD_W       = 8;
    localparam int PACE_W      = 32;
    localparam int ATT_W       = 4;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [ATT_W-1:0] ATT_RESET = 4'd3;

    localparam logic [APB_AW-3:0] REG_MAX_ATTEMPTS = 1'b0;

    typedef enum logic [1:0] {
        K_ENQ  = 2'd0,
        K_PACE = 2'd1,
        K_CONF = 2'd2,
        K_FAIL = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        FL_IDLE = 2'd0,
        FL_CMD  = 2'd1,
        FL_PACE = 2'd2
    } t_flight;

    typedef enum logic [1:0] {
        EV_NONE     = 2'd0,
        EV_REFUSED  = 2'd1,
        EV_DROPPED  = 2'd2,
        EV_GIVEN_UP = 2'd3
    } t_event;

    typedef struct packed {
        t_kind                    kind;
        logic [CMD_W-1:0]         command;
        logic signed [PACE_W-1:0] pace;
        logic                     outbox_free;
        logic                     send_accepted;
    } t_in_word;

    typedef struct packed {
        logic                     send_valid;
        logic                     send_is_pace;
        logic signed [PACE_W-1:0] send_value;
        logic [2:0]               queued_count;
        t_flight                  in_flight;
        t_event                   event_res;
    } t_out_word;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [CMD_W-1:0] wdata;
        logic [IDX_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

FILE: sv/retry_send_queue.sv
// top level of the retry send queue
//
// usage: one event word enters on i_cmd when start is high and busy is low.
// each accepted word yields exactly one result word on o_res, marked by
// o_done for a single cycle; the receiver cannot stall, so it must take the
// word in that cycle.
// timing: a word accepted at clock edge t is applied to the queue state and
// its command memory access is issued in that same cycle; busy is high for
// the next cycle while the registered read of the queue head comes back and
// the drain decision is made; o_done is high in the cycle after that.
// no new word is taken while busy is high, since the read of the command
// memory is registered.
// configuration: the retry limit sits at apb address 0 and may be written
// only while no word is being processed.
// reset: synchronous, active low; the queue empties, the pace slot clears,
// nothing is in flight and the retry limit returns to 3. the command memory
// itself is not cleared and needs no clearing pass.
`default_nettype none

module retry_send_queue (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire rsq_pkg::t_in_word             i_cmd,
    output logic                               o_done,
    output rsq_pkg::t_out_word                 o_res,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rsq_pkg::APB_AW-1:0]    paddr,
    input  wire logic [rsq_pkg::APB_DW-1:0]    pwdata,
    output logic      [rsq_pkg::APB_DW-1:0]    prdata,
    output logic                               pready
);

    logic [rsq_pkg::ATT_W-1:0] max_attempts;
    rsq_pkg::t_mem_req         mem_req;
    logic [rsq_pkg::CMD_W-1:0] mem_rdata;

    rsq_apb u_apb (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_max_attempts (max_attempts)
    );

    rsq_ram #(
        .WIDTH (rsq_pkg::CMD_W),
        .DEPTH (rsq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_rdata)
    );

    rsq_sched u_sched (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_max_attempts (max_attempts),
        .o_mem_req      (mem_req),
        .i_rdata        (mem_rdata),
        .o_done         (o_done),
        .o_res          (o_res)
    );

endmodule

`default_nettype wire

FILE: sv/rsq_ram.sv
// generic single-port-write ram with registered read
`default_nettype none

module rsq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 6
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: sv/rsq_apb.sv
// apb configuration register for the retry limit
`default_nettype none

module rsq_apb (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [rsq_pkg::APB_AW-1:0]    paddr,
    input  wire logic [rsq_pkg::APB_DW-1:0]    pwdata,
    output logic      [rsq_pkg::APB_DW-1:0]    prdata,
    output logic                               pready,
    output logic      [rsq_pkg::ATT_W-1:0]     o_max_attempts
);

    logic [rsq_pkg::ATT_W-1:0] r_max_att;
    logic [rsq_pkg::ATT_W-1:0] n_max_att;
    logic                      wr_hit;

    assign wr_hit = psel && penable && pwrite
                    && (paddr[rsq_pkg::APB_AW-1:2] == rsq_pkg::REG_MAX_ATTEMPTS);

    always_comb begin
        n_max_att = r_max_att;
        if (wr_hit) begin
            n_max_att = pwdata[rsq_pkg::ATT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_att <= rsq_pkg::ATT_RESET;
        end else begin
            r_max_att <= n_max_att;
        end
    end

    always_comb begin
        case (paddr[rsq_pkg::APB_AW-1:2])
            rsq_pkg::REG_MAX_ATTEMPTS: prdata = rsq_pkg::APB_DW'(r_max_att);
            default:                   prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign o_max_attempts = r_max_att;

endmodule

`default_nettype wire

FILE: sv/rsq_sched.sv
// event update and drain sequencer around the command memory
`default_nettype none
`include "retry_send_queue_macros.svh"

module rsq_sched (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire rsq_pkg::t_in_word             i_cmd,
    input  wire logic [rsq_pkg::ATT_W-1:0]     i_max_attempts,
    output rsq_pkg::t_mem_req                  o_mem_req,
    input  wire logic [rsq_pkg::CMD_W-1:0]     i_rdata,
    output logic                               o_done,
    output rsq_pkg::t_out_word                 o_res
);

    typedef enum logic {
        S_IDLE,
        S_DRN
    } t_state;

    t_state                          r_state, n_state;
    logic [rsq_pkg::IDX_W-1:0]       r_head, n_head;
    logic [rsq_pkg::CNT_W-1:0]       r_count, n_count;
    logic                            r_pend, n_pend;
    logic signed [rsq_pkg::PACE_W-1:0] r_pval, n_pval;
    rsq_pkg::t_flight                r_flight, n_flight;
    logic [rsq_pkg::ATT_W-1:0]       r_att, n_att;
    rsq_pkg::t_event                 r_ev, n_ev;
    logic                            r_run, n_run;
    logic                            r_obf, n_obf;
    logic                            r_acc, n_acc;
    logic                            r_fwd, n_fwd;
    logic [rsq_pkg::CMD_W-1:0]       r_fwd_data, n_fwd_data;
    logic                            r_done, n_done;
    rsq_pkg::t_out_word              r_res, n_res;
    rsq_pkg::t_mem_req               mem_req;
    logic                            accept;

    function automatic logic [rsq_pkg::IDX_W-1:0] idx_inc(
        input logic [rsq_pkg::IDX_W-1:0] idx
    );
        logic [rsq_pkg::IDX_W-1:0] res;
        if (32'(idx) == rsq_pkg::QUEUE_DEPTH - 1) begin
            res = '0;
        end else begin
            res = idx + 1'b1;
        end
        return res;
    endfunction

    function automatic logic [rsq_pkg::IDX_W-1:0] idx_add(
        input logic [rsq_pkg::IDX_W-1:0] idx,
        input logic [rsq_pkg::CNT_W-1:0] cnt
    );
        logic [rsq_pkg::CNT_W:0] sum;
        sum = (rsq_pkg::CNT_W + 1)'(idx) + (rsq_pkg::CNT_W + 1)'(cnt);
        if (32'(sum) >= rsq_pkg::QUEUE_DEPTH) begin
            sum = sum - (rsq_pkg::CNT_W + 1)'(rsq_pkg::QUEUE_DEPTH);
        end
        return rsq_pkg::IDX_W'(sum);
    endfunction

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state == S_DRN);

    always_comb begin
        logic [rsq_pkg::ATT_W-1:0] att_inc;
        logic                      send;
        logic [rsq_pkg::CMD_W-1:0] head_data;

        n_state    = r_state;
        n_head     = r_head;
        n_count    = r_count;
        n_pend     = r_pend;
        n_pval     = r_pval;
        n_flight   = r_flight;
        n_att      = r_att;
        n_ev       = r_ev;
        n_run      = r_run;
        n_obf      = r_obf;
        n_acc      = r_acc;
        n_fwd      = r_fwd;
        n_fwd_data = r_fwd_data;
        n_done     = 1'b0;
        n_res      = r_res;
        mem_req    = '0;
        att_inc    = r_att + 1'b1;
        send       = 1'b0;
        head_data  = r_fwd ? r_fwd_data : i_rdata;

        if (accept) begin
            n_ev  = rsq_pkg::EV_NONE;
            n_run = 1'b1;
            n_obf = i_cmd.outbox_free;
            n_acc = i_cmd.send_accepted;
            case (i_cmd.kind)
                rsq_pkg::K_ENQ: begin
                    if (32'(r_count) == rsq_pkg::QUEUE_DEPTH) begin
                        if (r_flight == rsq_pkg::FL_CMD) begin
                            n_ev  = rsq_pkg::EV_REFUSED;
                            n_run = 1'b0;
                        end else begin
                            n_head  = idx_inc(r_head);
                            n_count = r_count - 1'b1;
                            n_ev    = rsq_pkg::EV_DROPPED;
                        end
                    end
                    if (n_ev != rsq_pkg::EV_REFUSED) begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = idx_add(n_head, n_count);
                        mem_req.wdata = i_cmd.command;
                        n_count       = n_count + 1'b1;
                    end
                end
                rsq_pkg::K_PACE: begin
                    n_pval = i_cmd.pace;
                    n_pend = 1'b1;
                end
                rsq_pkg::K_CONF: begin
                    if (r_flight == rsq_pkg::FL_CMD && r_count != '0) begin
                        n_head  = idx_inc(r_head);
                        n_count = r_count - 1'b1;
                    end
                    n_flight = rsq_pkg::FL_IDLE;
                    n_att    = '0;
                end
                rsq_pkg::K_FAIL: begin
                    n_flight = rsq_pkg::FL_IDLE;
                    if (att_inc >= i_max_attempts) begin
                        if (r_flight == rsq_pkg::FL_CMD && r_count != '0) begin
                            n_head  = idx_inc(r_head);
                            n_count = r_count - 1'b1;
                        end
                        if (r_flight != rsq_pkg::FL_IDLE) begin
                            n_ev = rsq_pkg::EV_GIVEN_UP;
                        end
                        n_att = '0;
                    end else begin
                        n_att = att_inc;
                        if (r_flight == rsq_pkg::FL_PACE) begin
                            n_pend = 1'b1;
                        end
                    end
                end
                default: begin
                    n_run = 1'b1;
                end
            endcase
            mem_req.raddr = n_head;
            n_fwd         = mem_req.we && (mem_req.waddr == n_head);
            n_fwd_data    = i_cmd.command;
            n_state       = S_DRN;
        end

        if (r_state == S_DRN) begin
            send = r_run && (r_flight == rsq_pkg::FL_IDLE)
                   && (r_count != '0 || r_pend) && r_obf && r_acc;
            n_res.send_valid   = send;
            n_res.send_is_pace = 1'b0;
            n_res.send_value   = '0;
            if (send) begin
                if (r_count != '0) begin
                    n_res.send_value = rsq_pkg::PACE_W'(head_data);
                    n_flight         = rsq_pkg::FL_CMD;
                end else begin
                    n_res.send_is_pace = 1'b1;
                    n_res.send_value   = r_pval;
                    n_flight           = rsq_pkg::FL_PACE;
                    n_pend             = 1'b0;
                end
            end
            n_res.queued_count = 3'(r_count);
            n_res.in_flight    = n_flight;
            n_res.event_res    = r_ev;
            n_done             = 1'b1;
            n_state            = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_pend   <= 1'b0;
            r_pval   <= '0;
            r_flight <= rsq_pkg::FL_IDLE;
            r_att    <= '0;
            r_ev     <= rsq_pkg::EV_NONE;
            r_run    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_pend   <= n_pend;
            r_pval   <= n_pval;
            r_flight <= n_flight;
            r_att    <= n_att;
            r_ev     <= n_ev;
            r_run    <= n_run;
            r_done   <= n_done;
        end
        r_obf      <= n_obf;
        r_acc      <= n_acc;
        r_fwd      <= n_fwd;
        r_fwd_data <= n_fwd_data;
        r_res      <= n_res;
    end

    assign o_mem_req = mem_req;
    assign o_done    = r_done;
    assign o_res     = r_res;

    `RSQ_ASSERT_NEXT(a_drain_done, i_clk, i_rst_n, r_state == S_DRN, r_done, "drain without result")
    `RSQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, 32'(r_count) <= rsq_pkg::QUEUE_DEPTH, "fifo count overflow")
    `RSQ_ASSERT_NOW(a_send_flight, i_clk, i_rst_n, r_done && r_res.send_valid, r_res.in_flight != rsq_pkg::FL_IDLE, "send without flight")
    `RSQ_ASSERT_NOW(a_refuse_quiet, i_clk, i_rst_n, r_done && r_res.event_res == rsq_pkg::EV_REFUSED, !r_res.send_valid && r_res.in_flight == rsq_pkg::FL_CMD, "refused word sent")

endmodule

`default_nettype wire

FILE: sim/retry_send_queue_test.sv
// self-checking testbench for the retry send queue: directed and random events
`default_nettype none

module retry_send_queue_test;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 4;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start   = 1'b0;
    logic                         busy;
    rsq_pkg::t_in_word            i_cmd   = '0;
    logic                         o_done;
    rsq_pkg::t_out_word           o_res;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [rsq_pkg::APB_AW-1:0]   paddr   = '0;
    logic [rsq_pkg::APB_DW-1:0]   pwdata  = '0;
    logic [rsq_pkg::APB_DW-1:0]   prdata;
    logic                         pready;

    // scheduler state as predicted
    logic [rsq_pkg::CMD_W-1:0]         cmd_ring [rsq_pkg::QUEUE_DEPTH];
    int                                ring_head;
    int                                ring_count;
    logic                              pace_armed;
    logic signed [rsq_pkg::PACE_W-1:0] pace_slot;
    rsq_pkg::t_flight                  flight;
    logic [rsq_pkg::ATT_W-1:0]         fail_count;
    logic [rsq_pkg::ATT_W-1:0]         retry_limit;

    rsq_pkg::t_out_word pending_res[$];

    int errors      = 0;
    int words_sent  = 0;
    int link_sends  = 0;
    int drops       = 0;
    int refusals    = 0;
    int give_ups    = 0;
    int idle_cycles = 0;
    int no_idle_left = 0;

    retry_send_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_cmd   (i_cmd),
        .o_done  (o_done),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_err(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    function automatic void ring_pop();
        if (ring_count > 0) begin
            ring_head = (ring_head + 1) % rsq_pkg::QUEUE_DEPTH;
            ring_count--;
        end
    endfunction

    // applies one event word to the predicted state and returns the result word
    function automatic rsq_pkg::t_out_word apply_event(input rsq_pkg::t_in_word w);
        rsq_pkg::t_out_word r;
        rsq_pkg::t_flight   was;
        logic               drain_ok;
        r        = '0;
        drain_ok = 1'b1;
        case (w.kind)
            rsq_pkg::K_ENQ: begin
                if (ring_count >= rsq_pkg::QUEUE_DEPTH) begin
                    if (flight == rsq_pkg::FL_CMD) begin
                        r.event_res = rsq_pkg::EV_REFUSED;
                        drain_ok    = 1'b0;
                    end else begin
                        ring_pop();
                        r.event_res = rsq_pkg::EV_DROPPED;
                    end
                end
                if (r.event_res != rsq_pkg::EV_REFUSED) begin
                    cmd_ring[(ring_head + ring_count) % rsq_pkg::QUEUE_DEPTH] = w.command;
                    ring_count++;
                end
            end
            rsq_pkg::K_PACE: begin
                pace_slot  = w.pace;
                pace_armed = 1'b1;
            end
            rsq_pkg::K_CONF: begin
                if (flight == rsq_pkg::FL_CMD) ring_pop();
                flight     = rsq_pkg::FL_IDLE;
                fail_count = '0;
            end
            default: begin
                was        = flight;
                flight     = rsq_pkg::FL_IDLE;
                fail_count = fail_count + 1'b1;
                if (fail_count >= retry_limit) begin
                    if (was == rsq_pkg::FL_CMD) ring_pop();
                    if (was != rsq_pkg::FL_IDLE) r.event_res = rsq_pkg::EV_GIVEN_UP;
                    fail_count = '0;
                end else if (was == rsq_pkg::FL_PACE) begin
                    pace_armed = 1'b1;
                end
            end
        endcase
        if (drain_ok && flight == rsq_pkg::FL_IDLE && (ring_count > 0 || pace_armed)
                && w.outbox_free && w.send_accepted) begin
            r.send_valid = 1'b1;
            if (ring_count > 0) begin
                r.send_value = {24'd0, cmd_ring[ring_head]};
                flight       = rsq_pkg::FL_CMD;
            end else begin
                r.send_is_pace = 1'b1;
                r.send_value   = pace_slot;
                flight         = rsq_pkg::FL_PACE;
                pace_armed     = 1'b0;
            end
        end
        r.queued_count = 3'(ring_count);
        r.in_flight    = flight;
        return r;
    endfunction

    function automatic rsq_pkg::t_in_word mk_word(input rsq_pkg::t_kind k,
                                                  input logic [7:0] c,
                                                  input logic [31:0] p, input logic ob,
                                                  input logic acc);
        rsq_pkg::t_in_word w;
        w.kind          = k;
        w.command       = c;
        w.pace          = p;
        w.outbox_free   = ob;
        w.send_accepted = acc;
        return w;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        rsq_pkg::t_out_word e;
        if (o_done) begin
            if (pending_res.size() == 0) begin
                report_err("result word with nothing expected");
            end else begin
                e = pending_res.pop_front();
                if (o_res.send_valid !== e.send_valid)
                    report_err($sformatf("send_valid %b exp %b", o_res.send_valid,
                                         e.send_valid));
                if (o_res.send_is_pace !== e.send_is_pace)
                    report_err($sformatf("send_is_pace %b exp %b", o_res.send_is_pace,
                                         e.send_is_pace));
                if (o_res.send_value !== e.send_value)
                    report_err($sformatf("send_value %h exp %h", o_res.send_value,
                                         e.send_value));
                if (o_res.queued_count !== e.queued_count)
                    report_err($sformatf("queued_count %0d exp %0d", o_res.queued_count,
                                         e.queued_count));
                if (o_res.in_flight !== e.in_flight)
                    report_err($sformatf("in_flight %0d exp %0d", o_res.in_flight,
                                         e.in_flight));
                if (o_res.event_res !== e.event_res)
                    report_err($sformatf("event_res %0d exp %0d", o_res.event_res,
                                         e.event_res));
                if (e.send_valid) link_sends++;
                if (e.event_res == rsq_pkg::EV_DROPPED) drops++;
                if (e.event_res == rsq_pkg::EV_REFUSED) refusals++;
                if (e.event_res == rsq_pkg::EV_GIVEN_UP) give_ups++;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", pending_res.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_word(input rsq_pkg::t_in_word w);
        int gap;
        if (no_idle_left > 0) begin
            no_idle_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 17);
            if ($urandom_range(0, 59) == 0) no_idle_left = $urandom_range(10, 40);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        do @(posedge i_clk); while (busy);
        pending_res.push_back(apply_event(w));
        words_sent++;
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_res.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic wr, input logic [rsq_pkg::APB_DW-1:0] wdata,
                              output logic [rsq_pkg::APB_DW-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {rsq_pkg::REG_MAX_ATTEMPTS, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_limit_reg();
        logic [rsq_pkg::APB_DW-1:0] rd;
        reg_access(1'b0, '0, rd);
        if (rd !== rsq_pkg::APB_DW'(retry_limit))
            report_err($sformatf("max_attempts reads %0d exp %0d", rd, retry_limit));
    endtask

    task automatic set_retry_limit(input logic [rsq_pkg::ATT_W-1:0] v);
        logic [rsq_pkg::APB_DW-1:0] rd;
        wait_idle();
        reg_access(1'b1, rsq_pkg::APB_DW'(v), rd);
        retry_limit = v;
        check_limit_reg();
    endtask

    task automatic test_reset_state();
        check_limit_reg();
    endtask

    // full queue drop and refusal, coalesced pace, idle confirm and fail, retry to give-up
    task automatic test_directed_queue();
        send_word(mk_word(rsq_pkg::K_ENQ, 8'h00, 32'h0, 1'b0, 1'b1));
        send_word(mk_word(rsq_pkg::K_ENQ, 8'hFF, 32'h0, 1'b0, 1'b1));
        send_word(mk_word(rsq_pkg::K_PACE, 8'h00, 32'h7FFF_FFFF, 1'b0, 1'b1));
        send_word(mk_word(rsq_pkg::K_PACE, 8'h00, 32'h8000_0000, 1'b0, 1'b1));
        send_word(mk_word(rsq_pkg::K_ENQ, 8'h5A, 32'hFFFF_FFFF, 1'b0, 1'b1));
        send_word(mk_word(rsq_pkg::K_ENQ, 8'hA5, 32'h0, 1'b0, 1'b1));
        send_word(mk_word(rsq_pkg::K_ENQ, 8'h01, 32'h0, 1'b0, 1'b1));
        send_word(mk_word(rsq_pkg::K_ENQ, 8'h80, 32'h0, 1'b0, 1'b1));
        send_word(mk_word(rsq_pkg::K_ENQ, 8'h3C, 32'h0, 1'b0, 1'b1));
        send_word(mk_word(rsq_pkg::K_CONF, 8'h00, 32'h0, 1'b1, 1'b0));
        repeat (3) send_word(mk_word(rsq_pkg::K_FAIL, 8'h00, 32'h0, 1'b0, 1'b0));
        send_word(mk_word(rsq_pkg::K_CONF, 8'h00, 32'h0, 1'b1, 1'b1));
        send_word(mk_word(rsq_pkg::K_ENQ, 8'h77, 32'h0, 1'b1, 1'b1));
        repeat (3) send_word(mk_word(rsq_pkg::K_FAIL, 8'h00, 32'h0, 1'b1, 1'b1));
        send_word(mk_word(rsq_pkg::K_CONF, 8'h00, 32'h0, 1'b1, 1'b1));
        send_word(mk_word(rsq_pkg::K_PACE, 8'hFF, 32'h0000_0000, 1'b1, 1'b1));
        wait_idle();
    endtask

    task automatic test_random_traffic(input int n_items, input logic pause_midway);
        rsq_pkg::t_in_word w;
        int                r;
        int                fill_left;
        fill_left = 0;
        for (int i = 0; i < n_items; i++) begin
            if (pause_midway && i == n_items / 2) wait_idle();
            r = $urandom_range(0, 99);
            w.command       = 8'($urandom);
            w.pace          = ($urandom_range(0, 7) == 0) ?
                              (($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000)
                              : $urandom;
            w.outbox_free   = ($urandom_range(0, 9) != 0);
            w.send_accepted = ($urandom_range(0, 9) != 0);
            if (fill_left == 0 && $urandom_range(0, 39) == 0) fill_left = $urandom_range(6, 9);
            if (fill_left > 0) begin
                fill_left--;
                w.kind        = rsq_pkg::K_ENQ;
                w.outbox_free = ($urandom_range(0, 3) == 0);
            end else if (r < 12) begin
                w.kind          = rsq_pkg::t_kind'($urandom_range(0, 3));
                w.outbox_free   = 1'($urandom_range(0, 1));
                w.send_accepted = 1'($urandom_range(0, 1));
            end else if (flight != rsq_pkg::FL_IDLE) begin
                w.kind = (r < 55) ? rsq_pkg::K_CONF :
                         (r < 85) ? rsq_pkg::K_FAIL :
                         (r < 94) ? rsq_pkg::K_ENQ : rsq_pkg::K_PACE;
            end else begin
                w.kind = (r < 60) ? rsq_pkg::K_ENQ :
                         (r < 85) ? rsq_pkg::K_PACE :
                         (r < 93) ? rsq_pkg::K_CONF : rsq_pkg::K_FAIL;
            end
            send_word(w);
        end
        wait_idle();
    endtask

    initial begin
        for (int i = 0; i < rsq_pkg::QUEUE_DEPTH; i++) cmd_ring[i] = '0;
        ring_head   = 0;
        ring_count  = 0;
        pace_armed  = 1'b0;
        pace_slot   = '0;
        flight      = rsq_pkg::FL_IDLE;
        fail_count  = '0;
        retry_limit = rsq_pkg::ATT_RESET;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed_queue();
        test_random_traffic(225, 1'b0);
        set_retry_limit(4'd15);
        test_random_traffic(225, 1'b1);
        set_retry_limit(4'd1);
        test_random_traffic(225, 1'b0);
        set_retry_limit(4'd0);
        test_random_traffic(150, 1'b0);
        set_retry_limit(4'd7);
        test_random_traffic(225, 1'b0);
        set_retry_limit(4'($urandom_range(2, 14)));
        test_random_traffic(225, 1'b0);
        set_retry_limit(rsq_pkg::ATT_RESET);
        test_random_traffic(75, 1'b0);
        wait_idle();

        if (pending_res.size() != 0)
            report_err($sformatf("%0d results never arrived", pending_res.size()));
        $display("covered %0d event words under retry limits 3, 15, 1, 0, 7 and one random",
                 words_sent);
        $display("seen %0d link sends, %0d drops, %0d refusals, %0d give-ups; %0d errors",
                 link_sends, drops, refusals, give_ups, errors);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/rsq_pkg.sv
sv/rsq_ram.sv
sv/rsq_apb.sv
sv/rsq_sched.sv
sv/retry_send_queue.sv
sim/retry_send_queue_test.sv
